### hdl/prfl_pkg.sv
// shared constants and types for the page run free list allocator
package prfl_pkg;

  // address and page geometry
  localparam int unsigned ADDR_BITS  = 48;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PN_BITS    = ADDR_BITS - PAGE_SHIFT;

  // default depth of the run store
  localparam int unsigned RUN_DEPTH_DEF = 64;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one run entry in the store
  typedef struct packed {
    logic [PN_BITS-1:0] base;
    logic [PN_BITS-1:0] count;
  } run_t;

  // update request for the byte totals
  typedef struct packed {
    logic                 en;
    logic                 usable;
    logic [ADDR_BITS-1:0] len;
  } sum_upd_t;

endpackage

### hdl/page_run_free_list_allocator_unit.sv
// top level of the page run free list allocator
// an accepted word is latched, run in the execute state and its result registered
// a new word is taken only in the idle state, once the last word has left execute
// a stalled result holds the block in its execute state until taken
// reset clears the run top and both totals; run store contents stay undefined
// and need no clearing pass, since only entries below the top are used
module page_run_free_list_allocator_unit import prfl_pkg::*; #(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [ADDR_BITS-1:0] region_length_i,
  input  logic                 region_usable_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [ADDR_BITS-1:0] page_address_o,
  output logic [ADDR_BITS-1:0] total_bytes_o,
  output logic [ADDR_BITS-1:0] usable_bytes_o
);

  localparam int unsigned AW = $clog2(RUN_DEPTH);
  localparam int unsigned TW = $clog2(RUN_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e               state_q, state_d;
  logic [TW-1:0]        top_q, top_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q, status_d;
  logic [ADDR_BITS-1:0] page_q, page_d;

  // latched request word
  logic [1:0]           req_q;
  logic [PN_BITS-1:0]   addr_pn_q;
  logic [ADDR_BITS-1:0] len_q;
  logic                 usable_q;

  logic                 accept;
  logic                 fire;
  logic                 full;
  logic                 push_req;
  logic [PN_BITS-1:0]   push_cnt;
  logic [PN_BITS-1:0]   len_pages;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  run_t                 wr_data;
  logic [AW-1:0]        rd_addr;
  run_t                 rd_data;
  sum_upd_t             sum_upd;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign full       = (top_q == TW'(RUN_DEPTH));
  assign len_pages  = len_q[ADDR_BITS-1:PAGE_SHIFT];

  // read the top entry every cycle; data is ready in the execute cycle
  assign rd_addr = AW'(top_q - TW'(1));

  prfl_ram #(
    .WIDTH ($bits(run_t)),
    .DEPTH (RUN_DEPTH)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // byte totals update once per add region word
  assign sum_upd.en     = fire && (req_q == REQ_ADD);
  assign sum_upd.usable = usable_q;
  assign sum_upd.len    = len_q;

  prfl_sum u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (sum_upd),
    .total_o  (total_bytes_o),
    .usable_o (usable_bytes_o)
  );

  // execute: modify the top run and write it back
  always_comb begin
    logic               wr_req;
    wr_req   = 1'b0;
    push_req = 1'b0;
    push_cnt = PN_BITS'(1);
    wr_addr  = top_q[AW-1:0];
    wr_data  = '{base: addr_pn_q, count: PN_BITS'(1)};
    top_d    = top_q;
    status_d = ST_OK;
    page_d   = '0;
    unique case (req_q)
      REQ_ADD: begin
        if (usable_q && (len_pages != '0)) begin
          push_req = 1'b1;
          push_cnt = len_pages;
        end
      end
      REQ_ALLOC: begin
        if (top_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          page_d = {rd_data.base, {PAGE_SHIFT{1'b0}}};
          if (rd_data.count > PN_BITS'(1)) begin
            wr_req  = 1'b1;
            wr_addr = rd_addr;
            wr_data = '{base: rd_data.base + PN_BITS'(1),
                        count: rd_data.count - PN_BITS'(1)};
          end else begin
            top_d = top_q - TW'(1);
          end
        end
      end
      REQ_FREE: begin
        push_req = 1'b1;
      end
      default: begin
      end
    endcase
    // push a new run on top unless the store is full
    if (push_req) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        wr_req  = 1'b1;
        wr_addr = top_q[AW-1:0];
        wr_data = '{base: addr_pn_q, count: push_cnt};
        top_d   = top_q + TW'(1);
      end
    end
    wr_en = fire && wr_req;
  end

  // next state and output slot
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, run top and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      page_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        top_q    <= top_d;
        status_q <= status_d;
        page_q   <= page_d;
      end
    end
  end

  // capture the request word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      addr_pn_q <= address_i[ADDR_BITS-1:PAGE_SHIFT];
      len_q     <= region_length_i;
      usable_q  <= region_usable_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign page_address_o = page_q;

endmodule

### hdl/prfl_ram.sv
// generic single write port ram with registered read
module prfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/prfl_sum.sv
// saturating byte totals for all regions and usable regions
module prfl_sum import prfl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sum_upd_t             upd_i,
  output logic [ADDR_BITS-1:0] total_o,
  output logic [ADDR_BITS-1:0] usable_o
);

  logic [ADDR_BITS-1:0] total_q, total_d;
  logic [ADDR_BITS-1:0] usable_q, usable_d;
  logic [ADDR_BITS:0]   total_sum;
  logic [ADDR_BITS:0]   usable_sum;

  // saturating adds, carry out clamps to all ones
  always_comb begin
    total_sum  = {1'b0, total_q} + {1'b0, upd_i.len};
    usable_sum = {1'b0, usable_q} + {1'b0, upd_i.len};
    total_d    = total_q;
    usable_d   = usable_q;
    if (upd_i.en) begin
      total_d = total_sum[ADDR_BITS] ? '1 : total_sum[ADDR_BITS-1:0];
      if (upd_i.usable) begin
        usable_d = usable_sum[ADDR_BITS] ? '1 : usable_sum[ADDR_BITS-1:0];
      end
    end
  end

  // total registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      usable_q <= '0;
    end else begin
      total_q  <= total_d;
      usable_q <= usable_d;
    end
  end

  assign total_o  = total_q;
  assign usable_o = usable_q;

endmodule

### test/page_run_free_list_allocator_unit_tb.sv
// self-checking testbench for the page run free list allocator
`timescale 1ns / 100ps

module page_run_free_list_allocator_unit_tb import prfl_pkg::*; ();

  // request code that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] page_address;
    logic [ADDR_BITS-1:0] total_bytes;
    logic [ADDR_BITS-1:0] usable_bytes;
  } alloc_reply_t;

  // clock, reset and block ports
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i      = REQ_ADD;
  logic [ADDR_BITS-1:0] address_i       = '0;
  logic [ADDR_BITS-1:0] region_length_i = '0;
  logic                 region_usable_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [1:0]           status_o;
  logic [ADDR_BITS-1:0] page_address_o;
  logic [ADDR_BITS-1:0] total_bytes_o;
  logic [ADDR_BITS-1:0] usable_bytes_o;

  // predicted allocator state
  logic [PN_BITS-1:0]   free_run_base[RUN_DEPTH_DEF];
  logic [PN_BITS-1:0]   free_run_pages[RUN_DEPTH_DEF];
  int unsigned          free_run_top = 0;
  logic [ADDR_BITS-1:0] seen_total   = '0;
  logic [ADDR_BITS-1:0] seen_usable  = '0;

  // replies still owed by the block
  alloc_reply_t reply_q[$];
  int unsigned  err_cnt = 0;

  // pacing of both sides
  bit          pace_on      = 1'b0;
  int unsigned burst_left   = 0;
  rx_mode_e    rx_mode      = RX_READY;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned rx_cycle     = 0;

  page_run_free_list_allocator_unit #(
    .RUN_DEPTH(RUN_DEPTH_DEF)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .address_i      (address_i),
    .region_length_i(region_length_i),
    .region_usable_i(region_usable_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .page_address_o (page_address_o),
    .total_bytes_o  (total_bytes_o),
    .usable_bytes_o (usable_bytes_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // byte total that sticks at the top of the address range
  function automatic logic [ADDR_BITS-1:0] sat_add_bytes(input logic [ADDR_BITS-1:0] a,
                                                         input logic [ADDR_BITS-1:0] b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? '1 : s[ADDR_BITS-1:0];
  endfunction

  // push a run onto the predicted store, dropped when full
  function automatic logic [1:0] push_free_run(input logic [PN_BITS-1:0] base,
                                               input logic [PN_BITS-1:0] pages);
    if (free_run_top >= RUN_DEPTH_DEF) return ST_FULL;
    free_run_base[free_run_top]  = base;
    free_run_pages[free_run_top] = pages;
    free_run_top++;
    return ST_OK;
  endfunction

  // advance the predicted allocator by one request and return its reply
  function automatic alloc_reply_t compute_allocator_reply(input logic [1:0]           req,
                                                           input logic [ADDR_BITS-1:0] addr,
                                                           input logic [ADDR_BITS-1:0] len,
                                                           input logic                 usable);
    alloc_reply_t       r;
    logic [PN_BITS-1:0] pages;
    int unsigned        t;
    r = '0;
    case (req)
      REQ_ADD: begin
        seen_total = sat_add_bytes(seen_total, len);
        if (usable) begin
          seen_usable = sat_add_bytes(seen_usable, len);
          pages = len[ADDR_BITS-1:PAGE_SHIFT];
          if (pages != '0) r.status = push_free_run(addr[ADDR_BITS-1:PAGE_SHIFT], pages);
        end
      end
      REQ_ALLOC: begin
        if (free_run_top == 0) begin
          r.status = ST_EMPTY;
        end else begin
          t = free_run_top - 1;
          r.page_address = {free_run_base[t], {PAGE_SHIFT{1'b0}}};
          if (free_run_pages[t] > PN_BITS'(1)) begin
            free_run_base[t]  = free_run_base[t] + PN_BITS'(1);
            free_run_pages[t] = free_run_pages[t] - PN_BITS'(1);
          end else begin
            free_run_top = t;
          end
        end
      end
      REQ_FREE: r.status = push_free_run(addr[ADDR_BITS-1:PAGE_SHIFT], PN_BITS'(1));
      default: ;
    endcase
    r.total_bytes  = seen_total;
    r.usable_bytes = seen_usable;
    return r;
  endfunction

  // offer one word, wait for it to be taken, then maybe leave a gap
  task automatic send_word(input logic [1:0]           req,
                           input logic [ADDR_BITS-1:0] addr,
                           input logic [ADDR_BITS-1:0] len,
                           input logic                 usable);
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    address_i       <= addr;
    region_length_i <= len;
    region_usable_i <= usable;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reply_q.push_back(compute_allocator_reply(req, addr, len, usable));
    if (pace_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop valid and wait until every owed reply is back
  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    return ADDR_BITS'({$urandom, $urandom});
  endfunction

  // region lengths: mostly a few pages, some sub-page, some longer
  function automatic logic [ADDR_BITS-1:0] rand_region_len();
    logic [PN_BITS-1:0]    pages;
    logic [PAGE_SHIFT-1:0] frag;
    frag = PAGE_SHIFT'($urandom);
    case ($urandom_range(0, 9))
      0: pages = '0;
      1: begin
        pages = PN_BITS'(1);
        frag  = '0;
      end
      9: pages = PN_BITS'($urandom_range(9, 40));
      default: pages = PN_BITS'($urandom_range(1, 8));
    endcase
    return {pages, frag};
  endfunction

  // one random request with random content in every field
  task automatic send_random_word();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 18)      send_word(REQ_ADD, rand_addr(), rand_region_len(), 1'b1);
    else if (sel < 23) send_word(REQ_ADD, rand_addr(), rand_region_len(), 1'b0);
    else if (sel < 63) send_word(REQ_ALLOC, rand_addr(), rand_addr(), 1'($urandom));
    else if (sel < 93) send_word(REQ_FREE, rand_addr(), rand_addr(), 1'($urandom));
    else               send_word(REQ_UNUSED, rand_addr(), rand_addr(), 1'($urandom));
  endtask

  // edge values, every request type, fragments and address wrap
  task automatic test_directed();
    rx_mode = RX_READY;
    pace_on = 1'b0;
    send_word(REQ_ALLOC, '1, '1, 1'b1);
    send_word(REQ_UNUSED, '1, '1, 1'b1);
    send_word(REQ_FREE, '0, '0, 1'b0);
    send_word(REQ_ALLOC, '0, '0, 1'b0);
    send_word(REQ_ADD, 48'h0000_0010_0000, 48'h0000_0000_5007, 1'b0);
    send_word(REQ_ADD, 48'h0000_0020_0000, '0, 1'b1);
    send_word(REQ_ADD, 48'h0000_0030_0000, 48'h0000_0000_0fff, 1'b1);
    // low address bits below a page are ignored
    send_word(REQ_ADD, 48'h1234_5678_9abc, 48'h0000_0000_3fff, 1'b1);
    repeat (4) send_word(REQ_ALLOC, '0, '0, 1'b0);
    // run at the last page wraps to page zero
    send_word(REQ_ADD, '1, 48'h0000_0000_3000, 1'b1);
    repeat (3) send_word(REQ_ALLOC, '0, '0, 1'b0);
    send_word(REQ_FREE, '1, '0, 1'b1);
    send_word(REQ_FREE, 48'h5555_5555_5000, '1, 1'b0);
    repeat (2) send_word(REQ_ALLOC, '0, '0, 1'b0);
    send_word(REQ_UNUSED, '0, '0, 1'b0);
    send_word(REQ_ADD, 48'haaaa_aaaa_a000, 48'h0000_0000_1000, 1'b1);
    send_word(REQ_ALLOC, '0, '0, 1'b0);
  endtask

  // random mix with changing idle patterns on both sides
  task automatic test_random();
    for (int i = 0; i < 300; i++) begin
      if (i % 60 == 0) begin
        rx_mode = rx_mode_e'((i / 60) % 3);
        pace_on = ((i / 60) % 4) != 3;
      end
      send_random_word();
    end
  endtask

  // full rate, long receiver hold-off, then a sender pause
  task automatic test_backpressure();
    wait_for_replies();
    rx_mode = RX_READY;
    pace_on = 1'b0;
    repeat (20) send_random_word();
    hold_request = HOLD_CYCLES;
    repeat (25) send_random_word();
    wait_for_replies();
    rx_mode = RX_PATTERN;
    repeat (10) send_random_word();
  endtask

  // fill the run store, then push into it while full
  task automatic test_store_full();
    rx_mode = RX_RANDOM;
    pace_on = 1'b1;
    while (free_run_top < RUN_DEPTH_DEF) send_word(REQ_FREE, rand_addr(), rand_addr(), 1'b0);
    repeat (2) send_word(REQ_FREE, rand_addr(), rand_addr(), 1'b1);
    send_word(REQ_ADD, rand_addr(), rand_region_len() | 48'h1000, 1'b1);
    send_word(REQ_ADD, rand_addr(), 48'h0000_0000_0800, 1'b1);
  endtask

  // hand out pages until the store runs dry
  task automatic test_drain();
    int unsigned cnt;
    cnt = 0;
    rx_mode = RX_PATTERN;
    while (free_run_top != 0 && cnt < 300) begin
      send_word(REQ_ALLOC, rand_addr(), rand_addr(), 1'($urandom));
      cnt++;
    end
    repeat (2) send_word(REQ_ALLOC, rand_addr(), rand_addr(), 1'($urandom));
  endtask

  // both totals pinned at the top of the address range
  task automatic test_saturation();
    rx_mode = RX_RANDOM;
    send_word(REQ_ADD, rand_addr(), '1, 1'b0);
    send_word(REQ_ADD, '1, '1, 1'b1);
    repeat (2) send_word(REQ_ALLOC, '0, '0, 1'b0);
    send_word(REQ_ADD, rand_addr(), rand_addr(), 1'b1);
    send_word(REQ_ADD, rand_addr(), '0, 1'b1);
  endtask

  // receiver stall: long hold-off when asked, else the current pattern
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall_i <= ($urandom_range(0, 2) == 0);
        RX_PATTERN: out_stall_i <= ((rx_cycle % 7) < 2);
        default:    out_stall_i <= 1'b0;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [ADDR_BITS-1:0] exp_val,
                             input logic [ADDR_BITS-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
      err_cnt++;
    end
  endtask

  // compare each taken word with the oldest owed reply
  always @(posedge clk_i) begin
    alloc_reply_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual status %0d page 0x%0h",
                 $time, status_o, page_address_o);
        err_cnt++;
      end else begin
        exp_r = reply_q.pop_front();
        check_field("status", ADDR_BITS'(exp_r.status), ADDR_BITS'(status_o));
        check_field("page_address", exp_r.page_address, page_address_o);
        check_field("total_bytes", exp_r.total_bytes, total_bytes_o);
        check_field("usable_bytes", exp_r.usable_bytes, usable_bytes_o);
      end
    end
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_store_full();
    test_drain();
    test_saturation();
    wait_for_replies();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("page_run_free_list_allocator_unit regression: pass");
    end else begin
      $display("page_run_free_list_allocator_unit regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("page_run_free_list_allocator_unit regression: fail");
    $finish;
  end

endmodule
